// File: hw/rtl/vtyp_pkg.sv
// vector_to_yaw_pitch shared types, constants and the cordic arctangent table
// no dependencies

package vtyp_pkg;

	localparam int ACC_FRAC     = 24;
	localparam int ANG_W        = 35;
	localparam int CORDIC_STEPS = 30;
	localparam int NORM_BITS    = 30;
	localparam int SH_W         = 5;

	localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

	localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'd180 << ACC_FRAC);
	localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(64'd360 << ACC_FRAC);

	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic z_neg;
		logic z_pos;
		logic x_zero;
		logic xy_zero;
	} flags_t;

	function automatic int mag_width(input int cw);
		return (cw > NORM_BITS) ? cw : NORM_BITS;
	endfunction

	// atan(2^-i) in units of 2^-24 degree
	function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
		logic signed [ANG_W-1:0] a;
		unique case (i)
			0:  a = ANG_W'(754974720);
			1:  a = ANG_W'(445687602);
			2:  a = ANG_W'(235489088);
			3:  a = ANG_W'(119537938);
			4:  a = ANG_W'(60000934);
			5:  a = ANG_W'(30029717);
			6:  a = ANG_W'(15018523);
			7:  a = ANG_W'(7509720);
			8:  a = ANG_W'(3754917);
			9:  a = ANG_W'(1877466);
			10: a = ANG_W'(938734);
			11: a = ANG_W'(469367);
			12: a = ANG_W'(234684);
			13: a = ANG_W'(117342);
			14: a = ANG_W'(58671);
			15: a = ANG_W'(29335);
			16: a = ANG_W'(14668);
			17: a = ANG_W'(7334);
			18: a = ANG_W'(3667);
			19: a = ANG_W'(1833);
			20: a = ANG_W'(917);
			21: a = ANG_W'(458);
			22: a = ANG_W'(229);
			23: a = ANG_W'(115);
			24: a = ANG_W'(57);
			25: a = ANG_W'(29);
			26: a = ANG_W'(14);
			27: a = ANG_W'(7);
			28: a = ANG_W'(4);
			29: a = ANG_W'(2);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: hw/rtl/vtyp_norm.sv
// front end: magnitudes, flags, common left shift of x and y, cordic start vector
// depends on vtyp_pkg

module vtyp_norm
	import vtyp_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ce,
	input  logic                            in_valid,
	input  logic signed [COORD_WIDTH-1:0]   vec_x,
	input  logic signed [COORD_WIDTH-1:0]   vec_y,
	input  logic signed [COORD_WIDTH-1:0]   vec_z,
	output logic                            out_valid,
	output logic signed [mag_width(COORD_WIDTH)+2:0] out_x,
	output logic signed [mag_width(COORD_WIDTH)+2:0] out_y,
	output logic signed [ANG_W-1:0]         out_ang,
	output logic [COORD_WIDTH-1:0]          out_az,
	output logic [SH_W-1:0]                 out_sh,
	output flags_t                          out_flags
);

	localparam int MAG_W = mag_width(COORD_WIDTH);
	localparam int XW    = MAG_W + 3;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [COORD_WIDTH-1:0] ax_s1, ay_s1, az_s1;
	logic xn_s1, yn_s1, zn_s1;

	logic [MAG_W-1:0] m_s2, ax_s2, ay_s2;
	logic [COORD_WIDTH-1:0] az_s2, az_s3, az_s4, az_s5;
	flags_t flg_s2, flg_s3, flg_s4, flg_s5;

	logic [MAG_W-1:0] m_s3, ax_s3, ay_s3, ax_s4, ay_s4;
	logic [SH_W-1:0] sh_s3, sh_s4, sh_s5;

	logic [MAG_W-1:0] m_c3, ax_c3, ay_c3, m_c4, ax_c4, ay_c4;
	logic [SH_W-1:0] sh_c3, sh_c4;

	logic signed [XW-1:0] ay_w, cx_s5, cy_s5;
	logic signed [ANG_W-1:0] ang_s5;

	// coarse shift steps of 16 and 8
	always_comb begin
		m_c3  = m_s2;
		ax_c3 = ax_s2;
		ay_c3 = ay_s2;
		sh_c3 = '0;
		for (int j = SH_W - 1; j >= SH_W - 2; j--) begin
			if ((m_c3 >> (NORM_BITS - (1 << j))) == '0) begin
				m_c3      = m_c3 << (1 << j);
				ax_c3     = ax_c3 << (1 << j);
				ay_c3     = ay_c3 << (1 << j);
				sh_c3[j]  = 1'b1;
			end
		end
	end

	// fine shift steps of 4, 2 and 1
	always_comb begin
		m_c4  = m_s3;
		ax_c4 = ax_s3;
		ay_c4 = ay_s3;
		sh_c4 = sh_s3;
		for (int j = SH_W - 3; j >= 0; j--) begin
			if ((m_c4 >> (NORM_BITS - (1 << j))) == '0) begin
				m_c4      = m_c4 << (1 << j);
				ax_c4     = ax_c4 << (1 << j);
				ay_c4     = ay_c4 << (1 << j);
				sh_c4[j]  = 1'b1;
			end
		end
	end

	assign ay_w = signed'(XW'(ay_s4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ax_s1 <= vec_x[COORD_WIDTH-1] ? COORD_WIDTH'(-vec_x) : COORD_WIDTH'(vec_x);
			ay_s1 <= vec_y[COORD_WIDTH-1] ? COORD_WIDTH'(-vec_y) : COORD_WIDTH'(vec_y);
			az_s1 <= vec_z[COORD_WIDTH-1] ? COORD_WIDTH'(-vec_z) : COORD_WIDTH'(vec_z);
			xn_s1 <= vec_x[COORD_WIDTH-1];
			yn_s1 <= vec_y[COORD_WIDTH-1];
			zn_s1 <= vec_z[COORD_WIDTH-1];

			m_s2  <= MAG_W'((ax_s1 > ay_s1) ? ax_s1 : ay_s1);
			ax_s2 <= MAG_W'(ax_s1);
			ay_s2 <= MAG_W'(ay_s1);
			az_s2 <= az_s1;
			flg_s2.x_neg   <= xn_s1;
			flg_s2.y_neg   <= yn_s1;
			flg_s2.z_neg   <= zn_s1;
			flg_s2.z_pos   <= !zn_s1 && (az_s1 != '0);
			flg_s2.x_zero  <= (ax_s1 == '0);
			flg_s2.xy_zero <= (ax_s1 == '0) && (ay_s1 == '0);

			m_s3  <= m_c3;
			ax_s3 <= ax_c3;
			ay_s3 <= ay_c3;
			sh_s3 <= sh_c3;
			az_s3 <= az_s2;
			flg_s3 <= flg_s2;

			ax_s4 <= ax_c4;
			ay_s4 <= ay_c4;
			sh_s4 <= sh_c4;
			az_s4 <= az_s3;
			flg_s4 <= flg_s3;

			// left half plane is folded over with a half turn start angle
			if (flg_s4.x_zero) begin
				cx_s5  <= ay_w;
				cy_s5  <= '0;
				ang_s5 <= '0;
			end else begin
				cx_s5  <= signed'(XW'(ax_s4));
				cy_s5  <= (flg_s4.x_neg ^ flg_s4.y_neg) ? -ay_w : ay_w;
				ang_s5 <= flg_s4.x_neg ? HALF_TURN : '0;
			end
			sh_s5  <= sh_s4;
			az_s5  <= az_s4;
			flg_s5 <= flg_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_x     = cx_s5;
	assign out_y     = cy_s5;
	assign out_ang   = ang_s5;
	assign out_az    = az_s5;
	assign out_sh    = sh_s5;
	assign out_flags = flg_s5;

endmodule

// File: hw/rtl/vtyp_cordic.sv
// pipelined cordic vectoring unit, one micro-rotation per register stage
// depends on vtyp_pkg for the arctangent table

module vtyp_cordic
	import vtyp_pkg::*;
#(
	parameter int XW     = 35,
	parameter int SIDE_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ce,
	input  logic                     in_valid,
	input  logic signed [XW-1:0]     in_x,
	input  logic signed [XW-1:0]     in_y,
	input  logic signed [ANG_W-1:0]  in_ang,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic signed [XW-1:0]     out_x,
	output logic signed [ANG_W-1:0]  out_ang,
	output logic [SIDE_W-1:0]        out_side
);

	logic                    v_s    [CORDIC_STEPS];
	logic signed [XW-1:0]    x_s    [CORDIC_STEPS];
	logic signed [XW-1:0]    y_s    [CORDIC_STEPS];
	logic signed [ANG_W-1:0] a_s    [CORDIC_STEPS];
	logic [SIDE_W-1:0]       side_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic                    vi;
		logic signed [XW-1:0]    xi, yi;
		logic signed [ANG_W-1:0] ai;
		logic [SIDE_W-1:0]       si;
		logic                    up;

		if (i == 0) begin : g_head
			assign vi = in_valid;
			assign xi = in_x;
			assign yi = in_y;
			assign ai = in_ang;
			assign si = in_side;
		end else begin : g_tail
			assign vi = v_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign ai = a_s[i-1];
			assign si = side_s[i-1];
		end

		// rotate clockwise while y is strictly positive
		assign up = !yi[XW-1] && (yi != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (ce) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				if (up) begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					a_s[i] <= ai + atan_q24(i);
				end else begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					a_s[i] <= ai - atan_q24(i);
				end
				side_s[i] <= si;
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS-1];
	assign out_x     = x_s[CORDIC_STEPS-1];
	assign out_ang   = a_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];

endmodule

// File: hw/rtl/vtyp_zscale.sv
// pitch operands: z times cordic gain, aligned to the yaw magnitude, common right shift
// depends on vtyp_pkg

module vtyp_zscale
	import vtyp_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int SIDE_W      = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     ce,
	input  logic                                     in_valid,
	input  logic signed [mag_width(COORD_WIDTH)+2:0] in_r,
	input  logic [COORD_WIDTH-1:0]                   in_az,
	input  logic [SH_W-1:0]                          in_sh,
	input  logic                                     in_z_neg,
	input  logic [SIDE_W-1:0]                        in_side,
	output logic                                     out_valid,
	output logic signed [mag_width(COORD_WIDTH)+2:0] out_x,
	output logic signed [mag_width(COORD_WIDTH)+2:0] out_y,
	output logic [SIDE_W-1:0]                        out_side
);

	localparam int MAG_W = mag_width(COORD_WIDTH);
	localparam int XW    = MAG_W + 3;
	localparam int RW    = XW - 1;
	localparam int ZW    = COORD_WIDTH + $bits(GAIN_Q30);
	localparam int NSH   = $clog2(ZW - NORM_BITS + 1);
	localparam int PW    = SIDE_W + 1;

	logic valid_s1, valid_s2, valid_s4;
	logic [ZW-1:0] prod_s1, zk_s2;
	logic [RW-1:0] rk_s1, rk_s2;
	logic [SH_W-1:0] rsh_s1;
	logic [PW-1:0] pass_s1, pass_s2, pass_s4;

	logic          nv_s3 [NSH];
	logic [ZW-1:0] zn_s3 [NSH];
	logic [RW-1:0] rn_s3 [NSH];
	logic [PW-1:0] np_s3 [NSH];

	logic signed [XW-1:0] px_s4, py_s4, zmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s4 <= nv_s3[NSH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1 <= ZW'(in_az) * ZW'(GAIN_Q30);
			rk_s1   <= in_r[XW-1] ? '0 : in_r[RW-1:0];
			rsh_s1  <= SH_W'(NORM_BITS) - in_sh;
			pass_s1 <= {in_z_neg, in_side};

			zk_s2   <= prod_s1 >> rsh_s1;
			rk_s2   <= rk_s1;
			pass_s2 <= pass_s1;
		end
	end

	// shift both magnitudes right together until each is below 2^30
	for (genvar n = 0; n < NSH; n++) begin : g_norm
		localparam int K = 1 << (NSH - 1 - n);
		logic          vi;
		logic [ZW-1:0] zi;
		logic [RW-1:0] ri;
		logic [PW-1:0] pi;
		logic          go;

		if (n == 0) begin : g_head
			assign vi = valid_s2;
			assign zi = zk_s2;
			assign ri = rk_s2;
			assign pi = pass_s2;
		end else begin : g_tail
			assign vi = nv_s3[n-1];
			assign zi = zn_s3[n-1];
			assign ri = rn_s3[n-1];
			assign pi = np_s3[n-1];
		end

		assign go = |((zi | ZW'(ri)) >> (NORM_BITS - 1 + K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nv_s3[n] <= 1'b0;
			end else if (ce) begin
				nv_s3[n] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				zn_s3[n] <= go ? (zi >> K) : zi;
				rn_s3[n] <= go ? (ri >> K) : ri;
				np_s3[n] <= pi;
			end
		end
	end

	assign zmag = signed'(XW'(zn_s3[NSH-1][NORM_BITS-1:0]));

	always_ff @(posedge clk) begin
		if (ce) begin
			px_s4   <= signed'(XW'(rn_s3[NSH-1][NORM_BITS-1:0]));
			py_s4   <= np_s3[NSH-1][PW-1] ? -zmag : zmag;
			pass_s4 <= np_s3[NSH-1];
		end
	end

	assign out_valid = valid_s4;
	assign out_x     = px_s4;
	assign out_y     = py_s4;
	assign out_side  = pass_s4[SIDE_W-1:0];

endmodule

// File: hw/rtl/vtyp_out.sv
// output stages: wrap into one turn, round to output lsb, special cases, pitch negation
// depends on vtyp_pkg

module vtyp_out
	import vtyp_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ce,
	input  logic                              in_valid,
	input  logic signed [ANG_W-1:0]           in_yaw,
	input  logic signed [ANG_W-1:0]           in_pitch,
	input  flags_t                            in_flags,
	output logic                              out_valid,
	output logic signed [ANGLE_FRAC_BITS+9:0] neg_pitch,
	output logic [ANGLE_FRAC_BITS+8:0]        yaw_angle
);

	localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int UW = ANG_W - 1;
	localparam int QW = ANGLE_FRAC_BITS + 9;
	localparam int PW = ANGLE_FRAC_BITS + 10;

	localparam logic [UW-1:0] HALF_LSB = UW'(64'd1 << (SH - 1));
	localparam logic [UW-1:0] RND_LIM  = UW'(FULL_TURN) - HALF_LSB;
	localparam logic [QW-1:0] DEG_90   = QW'(64'd90 << ANGLE_FRAC_BITS);
	localparam logic [QW-1:0] DEG_270  = QW'(64'd270 << ANGLE_FRAC_BITS);

	logic valid_s1, valid_s2, valid_s3;
	logic [UW-1:0] yw_s1, pw_s1, ysum, psum;
	flags_t flg_s1;
	logic [QW-1:0] yq_s2, pq_s2, yaw_s3;
	logic signed [PW-1:0] np_s3;

	assign ysum = yw_s1 + HALF_LSB;
	assign psum = pw_s1 + HALF_LSB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			yw_s1  <= in_yaw[ANG_W-1] ? UW'(in_yaw + FULL_TURN) : UW'(in_yaw);
			pw_s1  <= in_pitch[ANG_W-1] ? UW'(in_pitch + FULL_TURN) : UW'(in_pitch);
			flg_s1 <= in_flags;

			// a value that rounds up to a full turn comes out as zero
			priority if (flg_s1.xy_zero) begin
				yq_s2 <= '0;
			end else if (flg_s1.x_zero) begin
				yq_s2 <= flg_s1.y_neg ? DEG_270 : DEG_90;
			end else if (yw_s1 >= RND_LIM) begin
				yq_s2 <= '0;
			end else begin
				yq_s2 <= ysum[SH +: QW];
			end

			priority if (flg_s1.xy_zero) begin
				pq_s2 <= flg_s1.z_pos ? DEG_90 : DEG_270;
			end else if (pw_s1 >= RND_LIM) begin
				pq_s2 <= '0;
			end else begin
				pq_s2 <= psum[SH +: QW];
			end

			yaw_s3 <= yq_s2;
			np_s3  <= signed'(PW'(0) - PW'(pq_s2));
		end
	end

	assign out_valid = valid_s3;
	assign neg_pitch = np_s3;
	assign yaw_angle = yaw_s3;

endmodule

// File: hw/rtl/vector_to_yaw_pitch.sv
// vector_to_yaw_pitch top level: direction vector to yaw and negated pitch
// depends on vtyp_pkg, vtyp_norm, vtyp_cordic, vtyp_zscale, vtyp_out

// Takes one signed direction vector per beat and returns yaw = atan2(y, x) and the
// negated pitch -atan2(z, hypot(x, y)), both wrapped into one turn and given in
// units of 2^-ANGLE_FRAC_BITS degree, within one lsb of exact rounding. A zero x
// and y gives yaw 0 and pitch 90 degrees for z > 0, else 270. The block takes a new
// vector every clock unless the pipeline holds, and most of its depth is the two
// 30-stage cordic vectoring pipelines, one for yaw and one for pitch. Items are
// independent. When the output beat is not taken the whole pipeline holds, so
// s_axis_tready follows m_axis_tready whenever the output register is full.

module vector_to_yaw_pitch
	import vtyp_pkg::*;
#(
	parameter int COORD_WIDTH     = 24,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vec_x, vec_y, vec_z from bit 0 up, zero padded to whole bytes
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// neg_pitch, yaw_angle from bit 0 up, zero padded to whole bytes
	output logic [((2*ANGLE_FRAC_BITS+19+7)/8)*8-1:0] m_axis_tdata
);

	localparam int MAG_W  = mag_width(COORD_WIDTH);
	localparam int XW     = MAG_W + 3;
	localparam int FLG_W  = $bits(flags_t);
	localparam int YSIDE  = COORD_WIDTH + SH_W + FLG_W;
	localparam int PSIDE  = ANG_W + FLG_W;
	localparam int OUT_W  = ((2*ANGLE_FRAC_BITS+19+7)/8)*8;
	localparam int RES_W  = 2*ANGLE_FRAC_BITS + 19;

	logic ce;

	logic signed [COORD_WIDTH-1:0] vec_x, vec_y, vec_z;

	logic                    nm_valid;
	logic signed [XW-1:0]    nm_x, nm_y;
	logic signed [ANG_W-1:0] nm_ang;
	logic [COORD_WIDTH-1:0]  nm_az;
	logic [SH_W-1:0]         nm_sh;
	flags_t                  nm_flags;

	logic                    yc_valid;
	logic signed [XW-1:0]    yc_r;
	logic signed [ANG_W-1:0] yc_ang;
	logic [YSIDE-1:0]        yc_side;
	logic [COORD_WIDTH-1:0]  yc_az;
	logic [SH_W-1:0]         yc_sh;
	flags_t                  yc_flags;

	logic                    zs_valid;
	logic signed [XW-1:0]    zs_x, zs_y;
	logic [PSIDE-1:0]        zs_side;

	logic                    pc_valid;
	logic signed [ANG_W-1:0] pc_ang;
	logic [PSIDE-1:0]        pc_side;
	logic signed [ANG_W-1:0] pc_yaw;
	flags_t                  pc_flags;

	logic                                 out_valid;
	logic signed [ANGLE_FRAC_BITS+9:0]    neg_pitch;
	logic [ANGLE_FRAC_BITS+8:0]           yaw_angle;

	assign ce            = !out_valid || m_axis_tready;
	assign s_axis_tready = ce;

	assign vec_x = signed'(s_axis_tdata[COORD_WIDTH-1:0]);
	assign vec_y = signed'(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
	assign vec_z = signed'(s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);

	vtyp_norm #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (s_axis_tvalid),
		.vec_x    (vec_x),
		.vec_y    (vec_y),
		.vec_z    (vec_z),
		.out_valid(nm_valid),
		.out_x    (nm_x),
		.out_y    (nm_y),
		.out_ang  (nm_ang),
		.out_az   (nm_az),
		.out_sh   (nm_sh),
		.out_flags(nm_flags)
	);

	vtyp_cordic #(
		.XW    (XW),
		.SIDE_W(YSIDE)
	) u_yaw_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (nm_valid),
		.in_x     (nm_x),
		.in_y     (nm_y),
		.in_ang   (nm_ang),
		.in_side  ({nm_az, nm_sh, nm_flags}),
		.out_valid(yc_valid),
		.out_x    (yc_r),
		.out_ang  (yc_ang),
		.out_side (yc_side)
	);

	assign {yc_az, yc_sh, yc_flags} = yc_side;

	vtyp_zscale #(
		.COORD_WIDTH(COORD_WIDTH),
		.SIDE_W     (PSIDE)
	) u_zscale (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (yc_valid),
		.in_r     (yc_r),
		.in_az    (yc_az),
		.in_sh    (yc_sh),
		.in_z_neg (yc_flags.z_neg),
		.in_side  ({yc_ang, yc_flags}),
		.out_valid(zs_valid),
		.out_x    (zs_x),
		.out_y    (zs_y),
		.out_side (zs_side)
	);

	vtyp_cordic #(
		.XW    (XW),
		.SIDE_W(PSIDE)
	) u_pitch_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (zs_valid),
		.in_x     (zs_x),
		.in_y     (zs_y),
		.in_ang   ('0),
		.in_side  (zs_side),
		.out_valid(pc_valid),
		.out_x    (),
		.out_ang  (pc_ang),
		.out_side (pc_side)
	);

	assign {pc_yaw, pc_flags} = pc_side;

	vtyp_out #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (pc_valid),
		.in_yaw   (pc_yaw),
		.in_pitch (pc_ang),
		.in_flags (pc_flags),
		.out_valid(out_valid),
		.neg_pitch(neg_pitch),
		.yaw_angle(yaw_angle)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {(OUT_W - RES_W)'(0), yaw_angle, neg_pitch};

endmodule

// File: tb/sv/testbench.sv
// self-checking bench for vector_to_yaw_pitch: directed table, then random vectors
// with gaps and stalls on both streams; expected angles come from an integer cordic model
// depends on vtyp_pkg.sv and vector_to_yaw_pitch.sv (and the submodules it instantiates)

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW       = 24;
	localparam int AFB      = 7;
	localparam int PW       = AFB + 10;
	localparam int YW       = AFB + 9;
	localparam int IN_W     = ((3*CW+7)/8)*8;
	localparam int OUT_W    = ((2*AFB+19+7)/8)*8;
	localparam int ROUND_SH = 24 - AFB;
	localparam int TURN_LSB = 360 << AFB;
	localparam int RAND_ITEMS = 1100;
	localparam int LIMIT    = 400000;
	localparam int DRAIN    = 120;

	localparam longint TURN_Q24 = 64'sd360 <<< 24;
	localparam longint unsigned GAIN_Q30 = 64'd1768195363;
	localparam longint unsigned NORM_LOW = 64'd1 << 29;
	localparam longint unsigned NORM_CAP = 64'd1 << 30;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [PW-1:0] NP_UP   = -(90 << AFB);
	localparam logic signed [PW-1:0] NP_DOWN = -(270 << AFB);

	typedef struct packed {
		logic signed [PW-1:0] neg_pitch;
		logic [YW-1:0]        yaw;
	} angle_pair_t;

	typedef struct {
		angle_pair_t angles;
		bit          exact;
	} angle_exp_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		bit                   typed;
		logic signed [PW-1:0] neg_pitch;
		logic [YW-1:0]        yaw;
	} vec_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	angle_exp_t pending_angles [$];
	int  errors;
	int  sent;
	int  checked;
	int  cycles;
	bit  no_idle;

	longint atan_tab [0:29] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
		14, 7, 4, 2
	};

	vec_row_t directed_tbl [0:24] = '{
		'{0, 0, 0, 1'b1, NP_DOWN, 0},
		'{0, 0, 1, 1'b1, NP_UP, 0},
		'{0, 0, -1, 1'b1, NP_DOWN, 0},
		'{0, 0, CMAX, 1'b1, NP_UP, 0},
		'{0, 0, CMIN, 1'b1, NP_DOWN, 0},
		'{0, 1, 0, 1'b0, 0, 0},
		'{0, -1, 0, 1'b0, 0, 0},
		'{0, CMAX, CMIN, 1'b0, 0, 0},
		'{0, CMIN, CMAX, 1'b0, 0, 0},
		'{1, 0, 0, 1'b0, 0, 0},
		'{-1, 0, 0, 1'b0, 0, 0},
		'{CMAX, 0, 0, 1'b0, 0, 0},
		'{CMIN, 0, 0, 1'b0, 0, 0},
		'{CMAX, CMAX, CMAX, 1'b0, 0, 0},
		'{CMIN, CMIN, CMIN, 1'b0, 0, 0},
		'{CMAX, CMIN, 0, 1'b0, 0, 0},
		'{CMIN, CMAX, CMAX, 1'b0, 0, 0},
		'{1, 1, 0, 1'b0, 0, 0},
		'{-1, -1, 1, 1'b0, 0, 0},
		'{1, 0, CMAX, 1'b0, 0, 0},
		'{1, 0, CMIN, 1'b0, 0, 0},
		'{CMAX, -1, 0, 1'b0, 0, 0},
		'{CMAX, -1, -1, 1'b0, 0, 0},
		'{5, -3, 7, 1'b0, 0, 0},
		'{-1, 1, -1, 1'b0, 0, 0}
	};

	vector_to_yaw_pitch #(
		.COORD_WIDTH(CW),
		.ANGLE_FRAC_BITS(AFB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// vectoring: angle of (xr, yv) in 2^-24 degree, xr returns gain times magnitude
	function automatic longint cordic_vector(inout longint xr, input longint yv);
		longint xv;
		longint dx;
		longint dy;
		longint ang;
		xv = xr;
		ang = 0;
		if (xv < 0) begin
			xv = -xv;
			yv = -yv;
			ang = TURN_Q24 / 2;
		end
		for (int i = 0; i < 30; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv > 0) begin
				xv = xv + dx;
				yv = yv - dy;
				ang = ang + atan_tab[i];
			end else begin
				xv = xv - dx;
				yv = yv + dy;
				ang = ang - atan_tab[i];
			end
		end
		xr = xv;
		return ang;
	endfunction

	function automatic int wrap_round(input longint a);
		longint q;
		while (a < 0)
			a = a + TURN_Q24;
		while (a >= TURN_Q24)
			a = a - TURN_Q24;
		q = (a + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
		if (q >= TURN_LSB)
			q = q - TURN_LSB;
		return int'(q);
	endfunction

	function automatic angle_pair_t aim_angles(input logic signed [CW-1:0] vx,
			input logic signed [CW-1:0] vy, input logic signed [CW-1:0] vz);
		longint x;
		longint y;
		longint z;
		longint xn;
		longint yn;
		longint r;
		longint px;
		longint pz;
		longint unsigned mx;
		longint unsigned my;
		longint unsigned m;
		longint unsigned zk;
		longint unsigned rk;
		int s;
		int yaw;
		int pitch;
		angle_pair_t res;
		x = longint'(vx);
		y = longint'(vy);
		z = longint'(vz);
		if (x == 0 && y == 0) begin
			yaw = 0;
			pitch = (z > 0 ? 90 : 270) << AFB;
		end else begin
			mx = (x < 0) ? -x : x;
			my = (y < 0) ? -y : y;
			m = (mx > my) ? mx : my;
			s = 0;
			while (m < NORM_LOW) begin
				m = m << 1;
				s++;
			end
			xn = mx << s;
			yn = my << s;
			if (x < 0)
				xn = -xn;
			if (y < 0)
				yn = -yn;
			r = xn;
			if (x == 0) begin
				r = yn;
				void'(cordic_vector(r, 0));
				yaw = (y > 0 ? 90 : 270) << AFB;
			end else begin
				yaw = wrap_round(cordic_vector(r, yn));
			end
			zk = (longint'(z < 0 ? -z : z) * GAIN_Q30) >> (30 - s);
			rk = (r < 0) ? 0 : r;
			while (zk >= NORM_CAP || rk >= NORM_CAP) begin
				zk = zk >> 1;
				rk = rk >> 1;
			end
			px = rk;
			pz = (z < 0) ? -longint'(zk) : longint'(zk);
			pitch = wrap_round(cordic_vector(px, pz));
		end
		res.neg_pitch = PW'(-pitch);
		res.yaw = YW'(yaw);
		return res;
	endfunction

	function automatic bit within_lsb(input int act, input int want);
		int d;
		d = (act - want + 2*TURN_LSB) % TURN_LSB;
		return d == 0 || d == 1 || d == TURN_LSB - 1;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		int r;
		int w;
		logic signed [CW-1:0] v;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			v = 0;
		end else if (r == 1) begin
			v = $urandom_range(0, 1) ? 1 : -1;
		end else if (r <= 4) begin
			w = $urandom_range(1, 12);
			v = CW'($urandom_range(0, (1 << w) - 1));
			if ($urandom_range(0, 1))
				v = -v;
		end else if (r == 5) begin
			v = $urandom_range(0, 1) ? CMAX : CMIN;
		end else begin
			v = CW'($urandom);
		end
		return v;
	endfunction

	task automatic send_vector(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
			input logic signed [CW-1:0] vz, input bit typed,
			input logic signed [PW-1:0] np, input logic [YW-1:0] yw);
		int gap;
		angle_exp_t want;
		gap = no_idle ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'({vz, vy, vx});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (typed) begin
			want.angles.neg_pitch = np;
			want.angles.yaw = yw;
			want.exact = 1'b1;
		end else begin
			want.angles = aim_angles(vx, vy, vz);
			want.exact = 1'b0;
		end
		pending_angles.push_back(want);
		sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d beats outstanding", $time, pending_angles.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// output side: random stall stretches, none while no_idle is set
	initial begin : ready_gen
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !no_idle) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = 0;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	always @(posedge clk) begin : result_check
		angle_exp_t want;
		logic signed [PW-1:0] got_np;
		logic [YW-1:0] got_yaw;
		bit np_ok;
		bit yaw_ok;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_np = m_axis_tdata[PW-1:0];
			got_yaw = m_axis_tdata[PW+YW-1:PW];
			if (m_axis_tdata[OUT_W-1:PW+YW] != '0) begin
				$display("%0t: pad bits expected 0, got %h", $time,
					m_axis_tdata[OUT_W-1:PW+YW]);
				errors++;
			end
			if (pending_angles.size() == 0) begin
				$display("%0t: result beat with nothing expected, neg_pitch %0d yaw %0d",
					$time, got_np, got_yaw);
				errors++;
			end else begin
				want = pending_angles.pop_front();
				checked++;
				np_ok = got_np <= 0 && got_np > -TURN_LSB;
				yaw_ok = got_yaw < TURN_LSB;
				if (want.exact) begin
					np_ok = np_ok && got_np == want.angles.neg_pitch;
					yaw_ok = yaw_ok && got_yaw == want.angles.yaw;
				end else begin
					np_ok = np_ok && within_lsb(-int'(got_np), -int'(want.angles.neg_pitch));
					yaw_ok = yaw_ok && within_lsb(int'(got_yaw), int'(want.angles.yaw));
				end
				if (!np_ok) begin
					$display("%0t: neg_pitch expected %0d, got %0d", $time,
						want.angles.neg_pitch, got_np);
					errors++;
				end
				if (!yaw_ok) begin
					$display("%0t: yaw_angle expected %0d, got %0d", $time,
						want.angles.yaw, got_yaw);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic signed [CW-1:0] vz;
		int r;
		errors = 0;
		sent = 0;
		checked = 0;
		cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_tbl[i])
			send_vector(directed_tbl[i].x, directed_tbl[i].y, directed_tbl[i].z,
				directed_tbl[i].typed, directed_tbl[i].neg_pitch, directed_tbl[i].yaw);

		for (int k = 0; k < RAND_ITEMS; k++) begin
			no_idle = ((k / 128) % 4) == 3;
			vx = rand_coord();
			vy = rand_coord();
			vz = rand_coord();
			r = $urandom_range(0, 19);
			if (r == 0)
				vx = 0;
			else if (r == 1)
				vy = 0;
			else if (r == 2) begin
				vx = 0;
				vy = 0;
			end
			send_vector(vx, vy, vz, 1'b0, '0, '0);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		no_idle = 1'b0;

		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d vectors sent (%0d from the directed table), %0d result beats checked",
			sent, $size(directed_tbl), checked);
		$display("covered zero, axis and full-scale vectors and random magnitudes, %s",
			"with gaps and stalls on both streams");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
